/* design/bpcr_pkg.sv */
// Shared types and constants for the clock replacement buffer pool.
// No dependencies; imported by every module of the block.
package bpcr_pkg;

  localparam int FILE_W   = 8;
  localparam int BLOCK_W  = 22;
  localparam int BYTES_W  = 17;
  localparam int OFFSET_W = 32;
  localparam int SLOT_W   = 6;

  localparam logic [BYTES_W-1:0] BLOCK_BYTES_RESET = BYTES_W'(4096);

  typedef struct packed {
    logic               pin;
    logic [BLOCK_W-1:0] block;
    logic [FILE_W-1:0]  file;
  } req_t;

  typedef struct packed {
    logic               valid;
    logic               recent;
    logic               pinned;
    logic [FILE_W-1:0]  file;
    logic [BLOCK_W-1:0] block;
  } entry_t;

  typedef struct packed {
    logic [BLOCK_W-1:0] ev_block;
    logic [FILE_W-1:0]  ev_file;
    logic               ev_valid;
    logic               no_victim;
    logic               hit;
    logic [SLOT_W-1:0]  slot;
  } res_t;

endpackage

/* design/bpcr_offset_mul.sv */
// Registered byte offset: block index times block size, low 32 bits.
// Depends on bpcr_pkg.
module bpcr_offset_mul (
  input  logic                             clk,
  input  logic [bpcr_pkg::BLOCK_W-1:0]     blk,
  input  logic [bpcr_pkg::BYTES_W-1:0]     bytes,
  output logic [bpcr_pkg::OFFSET_W-1:0]    offset
);
  import bpcr_pkg::*;

  localparam int PROD_W = BLOCK_W + BYTES_W;

  logic [PROD_W-1:0] prod;

  assign prod = PROD_W'(blk) * PROD_W'(bytes);

  always_ff @(posedge clk) begin
    offset <= prod[OFFSET_W-1:0];
  end

endmodule

/* design/bpcr_ctrl.sv */
// Slot table sequencer: clearing pass, serial tag lookup, clock sweep.
// Holds the slot memory; one entry is read and compared per step. Depends on bpcr_pkg.
module bpcr_ctrl #(
  parameter int SLOTS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  bpcr_pkg::req_t                in_req,
  output logic [bpcr_pkg::BLOCK_W-1:0]  req_block,
  output logic                          res_valid,
  input  logic                          res_ready,
  output bpcr_pkg::res_t                res
);
  import bpcr_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(2 * SLOTS);

  localparam logic [2:0] CLR  = 3'd0;
  localparam logic [2:0] IDLE = 3'd1;
  localparam logic [2:0] LRD  = 3'd2;
  localparam logic [2:0] LCMP = 3'd3;
  localparam logic [2:0] SRD  = 3'd4;
  localparam logic [2:0] SEVL = 3'd5;
  localparam logic [2:0] RES  = 3'd6;

  entry_t mem [SLOTS];
  entry_t rd_e;
  entry_t wdata;
  logic   we;
  logic [SW-1:0] waddr;
  logic [SW-1:0] raddr;

  logic [2:0]    state;
  logic [SW-1:0] idx;
  logic [SW-1:0] h;
  logic [SW-1:0] h_next;
  logic [SW-1:0] hand;
  logic [CW-1:0] steps;
  req_t          req;
  logic          tag_match;
  logic          take;

  assign raddr     = (state == SRD) ? h : idx;
  assign h_next    = (h == SW'(SLOTS - 1)) ? '0 : h + SW'(1);
  assign tag_match = rd_e.valid && (rd_e.file == req.file) && (rd_e.block == req.block);
  assign take      = !rd_e.valid || (!rd_e.recent && !rd_e.pinned);
  assign in_ready  = (state == IDLE);
  assign res_valid = (state == RES);
  assign req_block = req.block;

  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = rd_e;
    case (state)
      CLR: begin
        we    = 1'b1;
        wdata = '0;
      end
      LCMP: begin
        we           = tag_match;
        wdata.pinned = req.pin;
      end
      SEVL: begin
        waddr = h;
        if (take) begin
          we    = 1'b1;
          wdata = '{valid: 1'b1, recent: 1'b1, pinned: req.pin,
                    file: req.file, block: req.block};
        end else if (rd_e.recent) begin
          we           = 1'b1;
          wdata.recent = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_e <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CLR;
      idx   <= '0;
      hand  <= '0;
    end else begin
      case (state)
        CLR: begin
          idx <= (idx == SW'(SLOTS - 1)) ? '0 : idx + SW'(1);
          if (idx == SW'(SLOTS - 1)) state <= IDLE;
        end
        IDLE: begin
          if (in_valid) begin
            req   <= in_req;
            idx   <= '0;
            state <= LRD;
          end
        end
        LRD: state <= LCMP;
        LCMP: begin
          if (tag_match) begin
            res   <= '{ev_block: '0, ev_file: '0, ev_valid: 1'b0, no_victim: 1'b0,
                       hit: 1'b1, slot: SLOT_W'(idx)};
            state <= RES;
          end else if (idx == SW'(SLOTS - 1)) begin
            h     <= hand;
            steps <= '0;
            state <= SRD;
          end else begin
            idx   <= idx + SW'(1);
            state <= LRD;
          end
        end
        SRD: state <= SEVL;
        SEVL: begin
          if (take) begin
            res   <= '{ev_block: rd_e.valid ? rd_e.block : '0,
                       ev_file: rd_e.valid ? rd_e.file : '0,
                       ev_valid: rd_e.valid, no_victim: 1'b0,
                       hit: 1'b0, slot: SLOT_W'(h)};
            hand  <= h_next;
            state <= RES;
          end else if (steps == CW'(2 * SLOTS - 1)) begin
            res   <= '{ev_block: '0, ev_file: '0, ev_valid: 1'b0, no_victim: 1'b1,
                       hit: 1'b0, slot: '0};
            state <= RES;
          end else begin
            h     <= h_next;
            steps <= steps + CW'(1);
            state <= SRD;
          end
        end
        RES: begin
          if (res_ready) state <= IDLE;
        end
        default: state <= CLR;
      endcase
    end
  end

  a_res_exclusive: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.hit && res.no_victim) && !(res.hit && res.ev_valid)
                  && !(res.no_victim && res.ev_valid))
    else $error("conflicting result flags");

  a_cmp_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == LCMP) |-> ($past(state) == LRD))
    else $error("compare without a preceding read");

  a_accept_starts_lookup: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == LRD) && (idx == '0))
    else $error("accepted item did not start lookup at slot zero");

  a_sweep_from_read: assert property (@(posedge clk) disable iff (rst)
    (state == SEVL) |-> ($past(state) == SRD))
    else $error("sweep evaluation without a preceding read");

endmodule

/* design/buffer_pool_clock_replacement.sv */
// Top level of the clock (second chance) replacement buffer pool.
// Depends on bpcr_pkg, bpcr_ctrl and bpcr_offset_mul.
//
// Usage:
//   Requests enter on s_tvalid/s_tready/s_tdata, one item per request, and one
//   result item leaves on m_tvalid/m_tready/m_tdata for each. block_bytes is
//   written through cfg_wr_en/cfg_wr_data; the user must write it only while
//   the block is idle, since the block itself does not enforce this.
//   After reset the slot memory is cleared one entry per cycle with s_tready
//   low; cfg writes are taken throughout. Each step of the lookup and of the
//   clock sweep is one memory read and one compare. A hit stops the lookup,
//   which reads slots upward from slot zero. A miss scans all SLOTS entries,
//   then sweeps from the hand until it finds a victim, or gives no_victim
//   when every slot is pinned. One item is worked on at a time; the next can
//   be accepted in the cycle after the current result reaches the output
//   register. If m_tready stays low, that register holds its item and the
//   sequencer waits with the next result.
module buffer_pool_clock_replacement #(
  parameter int SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [16:0] cfg_wr_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // file_id[7:0], block_index[29:8], pin_request[30]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata    // slot[5:0], hit[6], no_victim[7], evicted_valid[8],
                                 // evicted_file[16:9], evicted_block[38:17],
                                 // load_offset[70:39]
);
  import bpcr_pkg::*;

  logic [BYTES_W-1:0]  block_bytes;
  logic [BLOCK_W-1:0]  req_block;
  logic [OFFSET_W-1:0] offset;
  req_t                in_req;
  res_t                res;
  logic                res_valid;
  logic                res_ready;

  assign in_req.file  = s_tdata[FILE_W-1:0];
  assign in_req.block = s_tdata[FILE_W+BLOCK_W-1:FILE_W];
  assign in_req.pin   = s_tdata[FILE_W+BLOCK_W];
  assign res_ready    = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_bytes <= BLOCK_BYTES_RESET;
    end else if (cfg_wr_en) begin
      block_bytes <= cfg_wr_data;
    end
  end

  bpcr_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_req    (in_req),
    .req_block (req_block),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  bpcr_offset_mul u_mul (
    .clk    (clk),
    .blk    (req_block),
    .bytes  (block_bytes),
    .offset (offset)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {1'b0, offset, res.ev_block, res.ev_file, res.ev_valid,
                  res.no_victim, res.hit, res.slot};
    end
  end

endmodule
